// ===== rtl/ath_pkg.sv =====
package ath_pkg;

    // Field widths fixed by the interface
    localparam int SEQ_W  = 62;
    localparam int HL_W   = 5;
    localparam int HASH_W = 64;
    localparam int TERM_W = 8;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = $clog2(SEQ_W + 1);

    localparam int DEF_MAX_HALF_LENGTH = 31;
    localparam int HALF_LENGTH_RESET   = 8;

    localparam logic [HASH_W-1:0] HASH_BASIS  = 64'd1469598103934665603;
    localparam logic [TERM_W-1:0] CORR_OFFSET = 8'd128;

    typedef struct packed {
        logic adv;
        logic apply;
        logic valid;
    } fnv_ctl_t;

    // Multiply by the FNV prime 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0, modulo 2^64
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
        logic [HASH_W-1:0] lo;
        lo = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);
        return lo + (x << 40);
    endfunction

endpackage

// ===== rtl/ath_corr.sv =====
module ath_corr #(
    parameter int SHIFT = 2
) (
    input  logic [ath_pkg::SEQ_W-1:0]  word,
    input  logic [ath_pkg::LEN_W-1:0]  len,
    output logic [ath_pkg::TERM_W-1:0] term
);
    import ath_pkg::*;

    localparam int NCH = (SEQ_W + 7) / 8;

    logic [LEN_W-1:0]   win_w;
    logic [SEQ_W-1:0]   win;
    logic [SEQ_W-1:0]   diff;
    logic [NCH*8-1:0]   diff_pad;
    logic [3:0]         chunk_cnt [NCH];
    logic [CNT_W-1:0]   ones;

    always_comb
    begin
        win_w    = len - LEN_W'(SHIFT);
        win      = ~({SEQ_W{1'b1}} << win_w);
        diff     = (word ^ (word >> SHIFT)) & win;
        diff_pad = (NCH*8)'(diff);
        // Count each byte, then add the byte counts
        for (int c = 0; c < NCH; c++)
        begin
            chunk_cnt[c] = '0;
            for (int b = 0; b < 8; b++)
            begin
                chunk_cnt[c] = chunk_cnt[c] + 4'(diff_pad[c*8 + b]);
            end
        end
        ones = '0;
        for (int c = 0; c < NCH; c++)
        begin
            ones = ones + CNT_W'(chunk_cnt[c]);
        end
        // C(s) + 128 stays within 8 bits, so modular arithmetic is exact
        term = TERM_W'(win_w) + CORR_OFFSET - TERM_W'({ones, 1'b0});
    end

endmodule

// ===== rtl/ath_fnv_stage.sv =====
module ath_fnv_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ath_pkg::fnv_ctl_t           ctl,
    input  logic [ath_pkg::HASH_W-1:0]  hash_in,
    input  logic [ath_pkg::TERM_W-1:0]  term,
    output logic                        valid_out,
    output logic [ath_pkg::HASH_W-1:0]  hash_out
);
    import ath_pkg::*;

    logic              valid_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;

    // Skip the step for shifts beyond N+1
    always_comb
    begin
        hash_next = ctl.apply ? fnv_mul(hash_in ^ HASH_W'(term)) : hash_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            hash_reg <= hash_next;
        end
    end

    assign valid_out = valid_reg;
    assign hash_out  = hash_reg;

endmodule

// ===== rtl/autocorrelation_tuple_hash.sv =====
// The mask register takes the beat at the accepting edge. The correlation stage, one
// FNV stage per shift and the output register follow it.
// Throughput: one beat per cycle while in_stall is low; the hash chain is a row
// of FNV stages, one multiply-by-prime each.
// A two-entry output (result register plus skid register) lets the pipe keep moving
// after the consumer stalls, until a beat lands in the skid register; in_stall is
// the registered skid-full flag. Reset (rst_n, async, active low) clears all valid bits
// and sets half_length to 8, or to MAX_HALF_LENGTH if that is smaller.
module autocorrelation_tuple_hash #(
    parameter int MAX_HALF_LENGTH = ath_pkg::DEF_MAX_HALF_LENGTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ath_pkg::HL_W-1:0]   half_length,
    // Input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ath_pkg::SEQ_W-1:0]  sequence_word,
    // Output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ath_pkg::HASH_W-1:0] tuple_hash
);
    import ath_pkg::*;

    localparam int MAXH = MAX_HALF_LENGTH;
    localparam int RESET_HL = (HALF_LENGTH_RESET > MAXH) ? MAXH : HALF_LENGTH_RESET;

    // Configuration register
    logic [HL_W-1:0]   half_length_reg;
    logic [HL_W-1:0]   half_length_next;
    logic [LEN_W-1:0]  seq_len;

    // Pipe advance: frozen only while the skid register holds a beat
    logic              adv;

    // Mask stage
    logic              s0_valid_reg;
    logic [SEQ_W-1:0]  s0_word_reg;
    logic [SEQ_W-1:0]  s0_word_next;

    // Correlation stage
    logic [TERM_W-1:0] term_next [MAXH];
    logic              s1_valid_reg;
    logic [TERM_W-1:0] term_reg [MAXH];

    // Hash chain
    logic [TERM_W-1:0] term_pipe_reg [MAXH][MAXH];
    logic              stage_valid [MAXH];
    logic [HASH_W-1:0] stage_hash [MAXH];

    // Output register and skid
    logic              out_valid_reg;
    logic [HASH_W-1:0] out_hash_reg;
    logic              skid_valid_reg;
    logic [HASH_W-1:0] skid_hash_reg;
    logic              out_free;
    logic              tail_valid;
    logic [HASH_W-1:0] tail_hash;

    // ---------------------------------------------------------------
    // Configuration: always ready, saturate N to the build maximum
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (half_length > HL_W'(MAXH))
        begin
            half_length_next = HL_W'(MAXH);
        end
        else
        begin
            half_length_next = half_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= HL_W'(RESET_HL);
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_length_reg <= half_length_next;
        end
    end

    assign seq_len = {half_length_reg, 1'b0};

    // ---------------------------------------------------------------
    // Flow control
    // ---------------------------------------------------------------
    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // ---------------------------------------------------------------
    // Mask stage: drop bits at or above 2N
    // ---------------------------------------------------------------
    assign s0_word_next = sequence_word & ~({SEQ_W{1'b1}} << seq_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_word_reg <= s0_word_next;
            term_reg    <= term_next;
        end
    end

    // ---------------------------------------------------------------
    // Correlation stage: one term C(s) + 128 per shift, all in parallel
    // ---------------------------------------------------------------
    for (genvar k = 0; k < MAXH; k++)
    begin : g_corr
        ath_corr #(
            .SHIFT (k + 2)
        ) u_corr (
            .word (s0_word_reg),
            .len  (seq_len),
            .term (term_next[k])
        );
    end

    // ---------------------------------------------------------------
    // Hash chain: stage k folds in the term for shift k+2 when k < N;
    // the remaining terms ride along with the beat
    // ---------------------------------------------------------------
    for (genvar k = 0; k < MAXH; k++)
    begin : g_hash
        ath_pkg::fnv_ctl_t ctl;
        logic [HASH_W-1:0] hash_in;
        logic [TERM_W-1:0] term_in;

        if (k == 0)
        begin : g_first
            assign hash_in   = HASH_BASIS;
            assign term_in   = term_reg[0];
            assign ctl.valid = s1_valid_reg;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    term_pipe_reg[0] <= term_reg;
                end
            end
        end
        else
        begin : g_rest
            assign hash_in   = stage_hash[k-1];
            assign term_in   = term_pipe_reg[k-1][k];
            assign ctl.valid = stage_valid[k-1];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    term_pipe_reg[k] <= term_pipe_reg[k-1];
                end
            end
        end

        assign ctl.adv   = adv;
        assign ctl.apply = (HL_W'(k) < half_length_reg);

        ath_fnv_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .hash_in   (hash_in),
            .term      (term_in),
            .valid_out (stage_valid[k]),
            .hash_out  (stage_hash[k])
        );
    end

    assign tail_valid = stage_valid[MAXH-1];
    assign tail_hash  = stage_hash[MAXH-1];

    // ---------------------------------------------------------------
    // Output register with skid: the tail beat lands in the output
    // register when it is free, else in the skid register
    // ---------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || tail_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg && tail_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_hash_reg <= skid_valid_reg ? skid_hash_reg : tail_hash;
        end
        else if (!skid_valid_reg)
        begin
            skid_hash_reg <= tail_hash;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tuple_hash = out_hash_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while the output register is empty");

    a_skid_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid register filled without a stalled output beat");

    a_hl_saturated : assert property (@(posedge clk) disable iff (!rst_n)
        half_length_reg <= HL_W'(MAXH))
        else $error("half_length register above the build maximum");

endmodule
